### src/mtep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types, widths and codes for the track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int MaxVlqBytes = 4;
  localparam int VlqWidth    = 28;
  localparam int CntWidth    = $clog2(MaxVlqBytes + 1);

  // Parser phases.
  localparam int PhaseWidth = 3;
  localparam logic [PhaseWidth-1:0] PH_DELTA = 3'd0;
  localparam logic [PhaseWidth-1:0] PH_CMD   = 3'd1;
  localparam logic [PhaseWidth-1:0] PH_P1    = 3'd2;
  localparam logic [PhaseWidth-1:0] PH_P2    = 3'd3;
  localparam logic [PhaseWidth-1:0] PH_MTYPE = 3'd4;
  localparam logic [PhaseWidth-1:0] PH_MLEN  = 3'd5;
  localparam logic [PhaseWidth-1:0] PH_MSKIP = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_CHANNEL   = 2'd0;
  localparam logic [1:0] KIND_UNHANDLED = 2'd1;
  localparam logic [1:0] KIND_END       = 2'd2;
  localparam logic [1:0] KIND_TRUNCATED = 2'd3;

  // Byte constants.
  localparam logic [7:0] META_CMD      = 8'hFF;
  localparam logic [7:0] META_END_TYPE = 8'h2F;
  localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
  localparam logic [3:0] HI_NOTE_ON    = 4'h9;
  localparam logic [3:0] HI_PROGRAM    = 4'hC;
  localparam logic [3:0] HI_PRESSURE   = 4'hD;
  localparam logic [3:0] HI_PITCH_BEND = 4'hE;

  typedef struct packed {
    logic [1:0]          kind;
    logic [VlqWidth-1:0] delta_time;
    logic [7:0]          command_byte;
    logic [7:0]          first_param;
    logic [7:0]          second_param;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_word_t;

endpackage

### src/mtep_core.sv
// ----------------------------------------------------------------------------
// MIDI track event parser core
// Parser state and the per-byte decode step; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module mtep_core import mtep_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_word_t word,
  output logic     res_valid,
  output result_t  res
);

  logic [PhaseWidth-1:0] phase_r, phase_nxt;
  logic [VlqWidth-1:0]   acc_r, acc_nxt;
  logic [CntWidth-1:0]   cnt_r, cnt_nxt;
  logic [VlqWidth-1:0]   delta_r, delta_nxt;
  logic [7:0]            cmd_r, cmd_nxt;
  logic [7:0]            param_r, param_nxt;
  logic [7:0]            mtype_r, mtype_nxt;
  logic [VlqWidth-1:0]   skip_r, skip_nxt;
  logic                  ended_r, ended_nxt;

  always_comb begin
    logic [PhaseWidth-1:0] ph;
    logic [VlqWidth-1:0]   acc;
    logic [CntWidth-1:0]   cnt;
    logic [VlqWidth-1:0]   dl;
    logic [7:0]            cm;
    logic [7:0]            pa;
    logic [7:0]            mt;
    logic [VlqWidth-1:0]   sk;
    logic                  en;
    logic [VlqWidth-1:0]   acc_f;
    logic [CntWidth-1:0]   cnt_f;
    logic                  vlq_done;
    logic [VlqWidth-1:0]   sk_dec;
    logic [7:0]            b;

    b = word.data_byte;
    // A first byte restarts the parser before the byte is decoded.
    if (word.first_byte) begin
      ph  = PH_DELTA;
      acc = '0;
      cnt = '0;
      dl  = '0;
      cm  = '0;
      pa  = '0;
      mt  = '0;
      sk  = '0;
      en  = 1'b0;
    end else begin
      ph  = phase_r;
      acc = acc_r;
      cnt = cnt_r;
      dl  = delta_r;
      cm  = cmd_r;
      pa  = param_r;
      mt  = mtype_r;
      sk  = skip_r;
      en  = ended_r;
    end

    acc_f    = {acc[VlqWidth-8:0], b[6:0]};
    cnt_f    = cnt + 1'b1;
    vlq_done = !b[7] || (cnt_f >= CntWidth'(MaxVlqBytes));
    sk_dec   = sk - 1'b1;

    phase_nxt = ph;
    acc_nxt   = acc;
    cnt_nxt   = cnt;
    delta_nxt = dl;
    cmd_nxt   = cm;
    param_nxt = pa;
    mtype_nxt = mt;
    skip_nxt  = sk;
    ended_nxt = en;
    res_valid = 1'b0;
    res       = '{kind: KIND_CHANNEL, delta_time: dl, command_byte: cm,
                  first_param: 8'h00, second_param: 8'h00};

    if (!en) begin
      case (phase_nxt)
        PH_DELTA: begin
          if (vlq_done) begin
            delta_nxt = acc_f;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_CMD;
          end else begin
            acc_nxt = acc_f;
            cnt_nxt = cnt_f;
          end
        end
        PH_CMD: begin
          cmd_nxt = b;
          if (b[7:4] inside {HI_NOTE_OFF, HI_NOTE_ON, HI_PITCH_BEND,
                             HI_PROGRAM, HI_PRESSURE}) begin
            phase_nxt = PH_P1;
          end else if (b == META_CMD) begin
            phase_nxt = PH_MTYPE;
          end else begin
            res_valid        = 1'b1;
            res.kind         = KIND_UNHANDLED;
            res.command_byte = b;
            phase_nxt        = PH_DELTA;
          end
        end
        PH_P1: begin
          if (cm[7:4] inside {HI_PROGRAM, HI_PRESSURE}) begin
            res_valid       = 1'b1;
            res.first_param = b;
            phase_nxt       = PH_DELTA;
          end else begin
            param_nxt = b;
            phase_nxt = PH_P2;
          end
        end
        PH_P2: begin
          res_valid        = 1'b1;
          res.first_param  = pa;
          res.second_param = b;
          phase_nxt        = PH_DELTA;
        end
        PH_MTYPE: begin
          mtype_nxt = b;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_MLEN;
        end
        PH_MLEN: begin
          if (vlq_done) begin
            skip_nxt = acc_f;
            acc_nxt  = '0;
            cnt_nxt  = '0;
            if (acc_f == '0) begin
              phase_nxt = PH_DELTA;
              if (mt == META_END_TYPE) begin
                ended_nxt        = 1'b1;
                res_valid        = 1'b1;
                res.kind         = KIND_END;
                res.command_byte = META_CMD;
                res.first_param  = META_END_TYPE;
              end
            end else begin
              phase_nxt = PH_MSKIP;
            end
          end else begin
            acc_nxt = acc_f;
            cnt_nxt = cnt_f;
          end
        end
        PH_MSKIP: begin
          skip_nxt = sk_dec;
          if (sk_dec == '0) begin
            phase_nxt = PH_DELTA;
            if (mt == META_END_TYPE) begin
              ended_nxt        = 1'b1;
              res_valid        = 1'b1;
              res.kind         = KIND_END;
              res.command_byte = META_CMD;
              res.first_param  = META_END_TYPE;
            end
          end
        end
        default: begin
          phase_nxt = PH_DELTA;
        end
      endcase

      // Last byte of the track: an unfinished event is reported as truncated.
      if (word.last_byte && !ended_nxt) begin
        if (phase_nxt != PH_DELTA || cnt_nxt != '0) begin
          res_valid        = 1'b1;
          res.kind         = KIND_TRUNCATED;
          res.delta_time   = (phase_nxt == PH_DELTA) ? '0 : delta_nxt;
          res.command_byte = (phase_nxt == PH_DELTA || phase_nxt == PH_CMD) ?
                             8'h00 : cmd_nxt;
          res.first_param  = 8'h00;
          res.second_param = 8'h00;
        end
        ended_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      acc_r   <= '0;
      cnt_r   <= '0;
      delta_r <= '0;
      cmd_r   <= '0;
      param_r <= '0;
      mtype_r <= '0;
      skip_r  <= '0;
      ended_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      delta_r <= delta_nxt;
      cmd_r   <= cmd_nxt;
      param_r <= param_nxt;
      mtype_r <= mtype_nxt;
      skip_r  <= skip_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

### src/mtep_out_buf.sv
// ----------------------------------------------------------------------------
// MIDI track event parser result buffer
// Two-entry result queue that decouples the parser from output stalls.
// ----------------------------------------------------------------------------
module mtep_out_buf import mtep_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic [1:0] count_r, count_nxt;
  result_t    slot0_r, slot0_nxt;
  result_t    slot1_r, slot1_nxt;
  logic       pop;

  assign pop       = (count_r != 2'd0) && out_ready;
  assign room      = (count_r != 2'd2) || out_ready;
  assign out_valid = (count_r != 2'd0);
  assign out_data  = slot0_r;

  always_comb begin
    count_nxt = count_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    case (count_r)
      2'd0: begin
        if (push) begin
          slot0_nxt = push_data;
          count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          slot0_nxt = push_data;
        end else if (push) begin
          slot1_nxt = push_data;
          count_nxt = 2'd2;
        end else if (pop) begin
          count_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          slot0_nxt = slot1_r;
          if (push) begin
            slot1_nxt = push_data;
          end else begin
            count_nxt = 2'd1;
          end
        end
      end
      default: begin
        count_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

### src/midi_track_event_parser_top.sv
// ----------------------------------------------------------------------------
// MIDI track event parser, top level
// Byte-serial track event decoder with an input register and result queue.
// ----------------------------------------------------------------------------
// Result path: the word that completes an event is held in the input register,
// and its result is then written into the result queue that drives out_valid.
// Throughput: one word per cycle, sustained while results are taken; the
// parser step is a single short decode between the two registers.
// Reset: rst_n is synchronous, active low, and returns the parser to waiting
// for a delta time with both the input register and result queue empty.
module midi_track_event_parser_top import mtep_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_first_byte,
  input  logic                in_last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [VlqWidth-1:0] out_delta_time,
  output logic [7:0]          out_command_byte,
  output logic [7:0]          out_first_param,
  output logic [7:0]          out_second_param
);

  // Input register. A held word is decoded once the result queue has room;
  // the queue always has room for one result whenever it can pop or is not
  // full, so decode and acceptance overlap in every cycle in which it has room.
  logic     stage_valid_r;
  in_word_t stage_word_r;
  logic     room;
  logic     advance;
  logic     res_valid;
  result_t  res;
  result_t  out_data;

  assign advance  = stage_valid_r && room;
  assign in_ready = !stage_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ready) begin
      stage_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      stage_word_r <= '{data_byte: in_data_byte, first_byte: in_first_byte,
                        last_byte: in_last_byte};
    end
  end

  // The parser state advances only when the held word is consumed, so any
  // stall on the result side freezes decoding without losing a word.
  mtep_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .word      (stage_word_r),
    .res_valid (res_valid),
    .res       (res)
  );

  mtep_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance && res_valid),
    .push_data (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_kind         = out_data.kind;
  assign out_delta_time   = out_data.delta_time;
  assign out_command_byte = out_data.command_byte;
  assign out_first_param  = out_data.first_param;
  assign out_second_param = out_data.second_param;

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// MIDI track event parser testbench
// Feeds hand-built and random track byte streams through the parser under
// valid/ready flow control, predicts every event it should report, and checks
// each reported event field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import mtep_pkg::*;

  localparam int ClkPeriod   = 12;
  localparam int ResetCycles = 10;
  // Generous run limit: far beyond the slowest legal run of this stimulus.
  localparam int LimitCycles = 400000;
  // The result passes the input register and the result queue; allow margin.
  localparam int DrainCycles = 10;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_data_byte = 8'h00;
  logic                in_first_byte = 1'b0;
  logic                in_last_byte = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_kind;
  logic [VlqWidth-1:0] out_delta_time;
  logic [7:0]          out_command_byte;
  logic [7:0]          out_first_param;
  logic [7:0]          out_second_param;

  midi_track_event_parser_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_first_byte    (in_first_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_delta_time   (out_delta_time),
    .out_command_byte (out_command_byte),
    .out_first_param  (out_first_param),
    .out_second_param (out_second_param)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Percentages of cycles in which the sender holds back a word and the
  // receiver refuses a result. Each random test sets them for its own phase.
  int send_idle_pct = 29;
  int recv_idle_pct = 68;
  int error_count = 0;

  // Events the parser still owes us, oldest first.
  result_t expected_events[$];

  // Bytes of the track currently being built and played.
  logic [7:0] track_bytes[$];

  // --------------------------------------------------------------------------
  // Event predictor. It keeps its own copy of the parser state and is stepped
  // once for every word the parser accepts.
  // --------------------------------------------------------------------------
  logic [PhaseWidth-1:0] parse_phase;
  logic [VlqWidth-1:0]   vlq_acc;
  int                    vlq_count;
  logic [VlqWidth-1:0]   event_delta;
  logic [7:0]            event_command;
  logic [7:0]            first_param_hold;
  logic [7:0]            meta_kind;
  logic [VlqWidth-1:0]   skip_left;
  logic                  track_done;

  function automatic void clear_parser();
    parse_phase      = PH_DELTA;
    vlq_acc          = '0;
    vlq_count        = 0;
    event_delta      = '0;
    event_command    = 8'h00;
    first_param_hold = 8'h00;
    meta_kind        = 8'h00;
    skip_left        = '0;
    track_done       = 1'b0;
  endfunction

  function automatic result_t make_result(input logic [1:0] k,
                                          input logic [VlqWidth-1:0] d,
                                          input logic [7:0] c,
                                          input logic [7:0] p1,
                                          input logic [7:0] p2);
    result_t r;
    r.kind         = k;
    r.delta_time   = d;
    r.command_byte = c;
    r.first_param  = p1;
    r.second_param = p2;
    return r;
  endfunction

  // Commands that carry one or two parameter bytes.
  function automatic logic takes_params(input logic [7:0] c);
    return c[7:4] inside {HI_NOTE_OFF, HI_NOTE_ON, HI_PITCH_BEND, HI_PROGRAM, HI_PRESSURE};
  endfunction

  // Shifts one variable-length byte in; the value is complete on a byte with
  // bit 7 clear or once the byte limit is reached, whatever bit 7 says.
  function automatic logic vlq_take(input logic [7:0] b);
    vlq_acc   = {vlq_acc[VlqWidth-8:0], b[6:0]};
    vlq_count = vlq_count + 1;
    return !b[7] || vlq_count >= MaxVlqBytes;
  endfunction

  // A meta event has been fully skipped; only the end-of-track type reports.
  function automatic logic close_meta(output result_t r);
    parse_phase = PH_DELTA;
    r = make_result(KIND_END, event_delta, META_CMD, META_END_TYPE, 8'h00);
    if (meta_kind == META_END_TYPE) begin
      track_done = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void decode_track_word(input logic [7:0] b, input logic first,
                                            input logic last);
    result_t r;
    logic    hit;
    hit = 1'b0;
    r = '0;
    if (first) clear_parser();
    if (track_done) return;
    case (parse_phase)
      PH_DELTA: begin
        if (vlq_take(b)) begin
          event_delta = vlq_acc;
          vlq_acc     = '0;
          vlq_count   = 0;
          parse_phase = PH_CMD;
        end
      end
      PH_CMD: begin
        event_command = b;
        if (takes_params(b)) begin
          parse_phase = PH_P1;
        end else if (b == META_CMD) begin
          parse_phase = PH_MTYPE;
        end else begin
          r = make_result(KIND_UNHANDLED, event_delta, b, 8'h00, 8'h00);
          hit = 1'b1;
          parse_phase = PH_DELTA;
        end
      end
      PH_P1: begin
        if (event_command[7:4] == HI_PROGRAM || event_command[7:4] == HI_PRESSURE) begin
          r = make_result(KIND_CHANNEL, event_delta, event_command, b, 8'h00);
          hit = 1'b1;
          parse_phase = PH_DELTA;
        end else begin
          first_param_hold = b;
          parse_phase = PH_P2;
        end
      end
      PH_P2: begin
        r = make_result(KIND_CHANNEL, event_delta, event_command, first_param_hold, b);
        hit = 1'b1;
        parse_phase = PH_DELTA;
      end
      PH_MTYPE: begin
        meta_kind   = b;
        vlq_acc     = '0;
        vlq_count   = 0;
        parse_phase = PH_MLEN;
      end
      PH_MLEN: begin
        if (vlq_take(b)) begin
          skip_left = vlq_acc;
          vlq_acc   = '0;
          vlq_count = 0;
          if (skip_left == '0) begin
            hit = close_meta(r);
          end else begin
            parse_phase = PH_MSKIP;
          end
        end
      end
      default: begin
        skip_left = skip_left - 1'b1;
        if (skip_left == '0) hit = close_meta(r);
      end
    endcase
    // The last word of a track closes it; an event still open is reported as
    // truncated with whatever of its delta time and command was already read.
    if (last && !track_done) begin
      if (parse_phase != PH_DELTA || vlq_count != 0) begin
        r = make_result(KIND_TRUNCATED,
                        (parse_phase == PH_DELTA) ? '0 : event_delta,
                        (parse_phase == PH_DELTA || parse_phase == PH_CMD) ?
                          8'h00 : event_command,
                        8'h00, 8'h00);
        hit = 1'b1;
      end
      track_done = 1'b1;
    end
    if (hit) expected_events.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Drives one word at the falling edge, optionally after some idle
  // cycles, holds it until the parser takes it, then steps the predictor.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b, input logic first, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_first_byte <= first;
    in_last_byte  <= last;
    do @(posedge clk); while (!in_ready);
    decode_track_word(b, first, last);
  endtask

  // Plays the built track; the first word restarts the parser and, if asked,
  // the final word is flagged as the end of the track data.
  task automatic play_track(input logic mark_last);
    int i;
    for (i = 0; i < track_bytes.size(); i++) begin
      send_word(track_bytes[i], i == 0, mark_last && i == track_bytes.size() - 1);
    end
  endtask

  // Appends a value as a variable-length quantity of exactly nb bytes.
  task automatic push_vlq(input logic [VlqWidth-1:0] v, input int nb);
    int i;
    for (i = nb - 1; i >= 0; i--) begin
      track_bytes.push_back({i > 0, v[7*i +: 7]});
    end
  endtask

  // Builds a random track: mostly well-formed events with random content,
  // with overlong delta times, stray bytes, huge meta lengths, cut-off tracks
  // and tracks that simply stop without a final word mixed in.
  task automatic build_track(output logic mark_last);
    int          n_events;
    int          sel;
    int          nb;
    int          len;
    int          i;
    int          cut;
    logic [7:0]  c;
    logic [27:0] v;
    logic        stop;
    track_bytes.delete();
    stop = 1'b0;
    n_events = $urandom_range(1, 10);
    for (i = 0; i < n_events && !stop; i++) begin
      sel = $urandom_range(99);
      if (sel < 5) begin
        // Delta time that still says "more follows" on its last allowed byte.
        repeat (MaxVlqBytes) track_bytes.push_back(8'($urandom_range(128, 255)));
      end else begin
        nb = $urandom_range(1, MaxVlqBytes);
        v = (nb == MaxVlqBytes && $urandom_range(9) == 0) ? 28'h0FFFFFFF : 28'($urandom);
        v = v & ((28'd1 << (7 * nb)) - 1'b1);
        push_vlq(v, nb);
      end
      sel = $urandom_range(99);
      if (sel < 30) begin
        case ($urandom_range(2))
          0: c = {HI_NOTE_OFF, 4'($urandom)};
          1: c = {HI_NOTE_ON, 4'($urandom)};
          default: c = {HI_PITCH_BEND, 4'($urandom)};
        endcase
        track_bytes.push_back(c);
        track_bytes.push_back(8'($urandom));
        track_bytes.push_back(8'($urandom));
      end else if (sel < 50) begin
        c = {($urandom_range(1) == 0) ? HI_PROGRAM : HI_PRESSURE, 4'($urandom)};
        track_bytes.push_back(c);
        track_bytes.push_back(8'($urandom));
      end else if (sel < 62) begin
        do c = 8'($urandom); while (takes_params(c) || c == META_CMD);
        track_bytes.push_back(c);
      end else if (sel < 80) begin
        track_bytes.push_back(META_CMD);
        do c = 8'($urandom); while (c == META_END_TYPE);
        track_bytes.push_back(c);
        len = $urandom_range(0, 4);
        push_vlq(28'(len), $urandom_range(1, 2));
        repeat (len) track_bytes.push_back(8'($urandom));
      end else if (sel < 85) begin
        // A meta event far longer than the track: it can only end truncated.
        track_bytes.push_back(META_CMD);
        track_bytes.push_back(8'($urandom));
        push_vlq(28'($urandom_range(32'h0010_0000, 32'h0FFF_FFFF)), MaxVlqBytes);
        repeat ($urandom_range(1, 3)) track_bytes.push_back(8'($urandom));
        stop = 1'b1;
      end else if (sel < 93) begin
        track_bytes.push_back(META_CMD);
        track_bytes.push_back(META_END_TYPE);
        len = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        push_vlq(28'(len), 1);
        repeat (len) track_bytes.push_back(8'($urandom));
        // Anything after the end of the track must be ignored.
        repeat ($urandom_range(0, 3)) track_bytes.push_back(8'($urandom));
        stop = 1'b1;
      end else begin
        repeat ($urandom_range(1, 3)) track_bytes.push_back(8'($urandom));
      end
    end
    if ($urandom_range(4) == 0) begin
      cut = $urandom_range(1, track_bytes.size());
      while (track_bytes.size() > cut) void'(track_bytes.pop_back());
    end
    mark_last = ($urandom_range(4) != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Every channel command with extreme data bytes, the largest delta time, a
  // delta time cut short by the byte limit, and an unhandled command.
  task automatic test_channel_events();
    track_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h90, 8'hFF, 8'h00,
                    8'h00, 8'h80, 8'h00, 8'h7F,
                    8'h7F, 8'hC5, 8'h7F,
                    8'h81, 8'h00, 8'hD2, 8'h40,
                    8'h00, 8'hEF, 8'h00, 8'h80,
                    8'h00, 8'hF0};
    play_track(1'b0);
  endtask

  // A skipped meta event, the end of track with a byte after it, and tracks
  // cut off after a command and in the middle of a delta time.
  task automatic test_meta_and_truncation();
    track_bytes = '{8'h00, 8'hFF, 8'h01, 8'h01, 8'h33,
                    8'h05, 8'hFF, 8'h2F, 8'h00,
                    8'h90};
    play_track(1'b0);
    track_bytes = '{8'h00, 8'h90};
    play_track(1'b1);
    track_bytes = '{8'h81};
    play_track(1'b1);
  endtask

  task automatic test_random_tracks(input int send_pct, input int recv_pct,
                                    input int word_budget);
    int   sent;
    logic mark_last;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < word_budget) begin
      build_track(mark_last);
      play_track(mark_last);
      sent += track_bytes.size();
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver and result checker.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event: kind %0d delta %0d command %02h params %02h %02h",
               out_kind, out_delta_time, out_command_byte, out_first_param,
               out_second_param);
        error_count++;
      end else begin
        want = expected_events.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_kind);
          error_count++;
        end
        if (out_delta_time !== want.delta_time) begin
          $error("delta_time: expected %0d, got %0d", want.delta_time, out_delta_time);
          error_count++;
        end
        if (out_command_byte !== want.command_byte) begin
          $error("command_byte: expected %02h, got %02h", want.command_byte,
                 out_command_byte);
          error_count++;
        end
        if (out_first_param !== want.first_param) begin
          $error("first_param: expected %02h, got %02h", want.first_param,
                 out_first_param);
          error_count++;
        end
        if (out_second_param !== want.second_param) begin
          $error("second_param: expected %02h, got %02h", want.second_param,
                 out_second_param);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    clear_parser();
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    // Slow receiver first, then slow sender, then full rate both ways.
    send_idle_pct = 29;
    recv_idle_pct = 68;
    test_channel_events();
    test_meta_and_truncation();
    test_random_tracks(29, 68, 460);
    test_random_tracks(68, 29, 460);
    test_random_tracks(0, 0, 460);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    // Any stray event would show up within the pipeline latency.
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(ClkPeriod * LimitCycles);
    $display("Verification failed");
    $finish;
  end

endmodule
